FILE: rtl/lpmr_pkg.sv
package lpmr_pkg;

  localparam int LEN_W  = 7;
  localparam int BYTE_W = 8;

  // request kinds
  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_READ  = 1'b1
  } req_kind_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_WRITE_OK       = 3'd0,
    ST_WRITE_FULL     = 3'd1,
    ST_READ_OK        = 3'd2,
    ST_READ_EMPTY     = 3'd3,
    ST_READ_TOO_SMALL = 3'd4
  } status_t;

  // one input word
  typedef struct packed {
    req_kind_t          req_type;
    logic               first;
    logic               last;
    logic [LEN_W-1:0]   msg_len;
    logic [BYTE_W-1:0]  data_byte;
    logic [BYTE_W-1:0]  read_capacity;
  } req_t;

  // one result word
  typedef struct packed {
    status_t            status;
    logic [LEN_W-1:0]   out_len;
    logic [BYTE_W-1:0]  out_byte;
    logic               byte_valid;
    logic               last_out;
  } result_t;

endpackage

FILE: rtl/lpmr_ram.sv
module lpmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/lpmr_wr.sv
module lpmr_wr #(
  parameter int RING_BYTES    = 1024,
  parameter int HEADER_BYTES  = 8,
  parameter int MAX_MSG_BYTES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  lpmr_pkg::req_t                req,
  input  logic [$clog2(RING_BYTES)-1:0] head,
  output logic [$clog2(RING_BYTES)-1:0] tail,
  output logic                          busy,
  output logic                          we,
  output logic [$clog2(RING_BYTES)-1:0] waddr,
  output logic [7:0]                    wdata,
  output lpmr_pkg::result_t             res,
  output logic                          res_valid
);
  import lpmr_pkg::*;

  localparam int AW  = $clog2(RING_BYTES);
  localparam int FW  = AW + 1;
  localparam int CW  = (FW > 8) ? FW : 8;
  localparam int HCW = $clog2(HEADER_BYTES + 1);
  localparam logic [LEN_W-1:0] MAXL = LEN_W'(MAX_MSG_BYTES);

  typedef enum logic [1:0] {
    W_IDLE   = 2'b01,
    W_COMMIT = 2'b10
  } wstate_t;

  wstate_t            state;
  logic [AW-1:0]      wptr;
  logic [AW-1:0]      cptr;
  logic               wopen;
  logic               wrefused;
  logic [LEN_W-1:0]   brecv;
  logic [LEN_W-1:0]   decl;
  logic [HCW-1:0]     cnt;

  logic [FW-1:0]      sum_h;
  logic [AW-1:0]      tail_h;
  logic [FW-1:0]      free_sp;
  logic [CW-1:0]      need;
  logic               refuse_f;
  logic               open_e;
  logic               refused_e;
  logic [LEN_W-1:0]   br_e;
  logic [LEN_W-1:0]   decl_e;
  logic [AW-1:0]      wptr_e;
  logic               store;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == AW'(RING_BYTES - 1)) r = '0;
    else                          r = p + AW'(1);
    return r;
  endfunction

  // free space and admission check for a new message
  always_comb begin
    sum_h  = {1'b0, tail} + FW'(HEADER_BYTES);
    tail_h = (sum_h >= FW'(RING_BYTES)) ? AW'(sum_h - FW'(RING_BYTES)) : sum_h[AW-1:0];
    if (head <= tail) free_sp = FW'(RING_BYTES) - ({1'b0, tail} - {1'b0, head});
    else              free_sp = {1'b0, head} - {1'b0, tail};
    need     = CW'(HEADER_BYTES) + CW'(req.msg_len);
    refuse_f = (req.msg_len > MAXL) || (need >= CW'(free_sp));
  end

  // write context as seen after a possible first word
  always_comb begin
    open_e    = req.first | wopen;
    refused_e = req.first ? refuse_f : wrefused;
    br_e      = req.first ? '0 : brecv;
    decl_e    = req.first ? req.msg_len : decl;
    wptr_e    = req.first ? tail_h : wptr;
    store     = go && (state == W_IDLE) && open_e && !refused_e && (br_e < decl_e);
  end

  // memory write port: data bytes, then the header sweep
  always_comb begin
    if (state == W_COMMIT) begin
      we    = 1'b1;
      waddr = cptr;
      wdata = (cnt == '0) ? {1'b0, brecv} : 8'h00;
    end else begin
      we    = store;
      waddr = wptr_e;
      wdata = req.data_byte;
    end
  end

  assign busy = (state == W_COMMIT);

  // write sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= W_IDLE;
      tail      <= '0;
      wptr      <= '0;
      wopen     <= 1'b0;
      wrefused  <= 1'b0;
      brecv     <= '0;
      decl      <= '0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      unique case (state)
        W_IDLE: begin
          if (go && open_e) begin
            wopen    <= 1'b1;
            wrefused <= refused_e;
            decl     <= decl_e;
            wptr     <= store ? ptr_inc(wptr_e) : wptr_e;
            brecv    <= br_e + LEN_W'(store);
            if (req.last) begin
              if (refused_e) begin
                res.status     <= ST_WRITE_FULL;
                res.out_len    <= decl_e;
                res.out_byte   <= '0;
                res.byte_valid <= 1'b0;
                res.last_out   <= 1'b1;
                res_valid      <= 1'b1;
                wopen          <= 1'b0;
                wrefused       <= 1'b0;
              end else begin
                state <= W_COMMIT;
                cptr  <= tail;
                cnt   <= '0;
              end
            end
          end
        end
        W_COMMIT: begin
          cptr <= ptr_inc(cptr);
          cnt  <= cnt + HCW'(1);
          if (cnt == HCW'(HEADER_BYTES - 1)) begin
            tail           <= wptr;
            wopen          <= 1'b0;
            res.status     <= ST_WRITE_OK;
            res.out_len    <= brecv;
            res.out_byte   <= '0;
            res.byte_valid <= 1'b0;
            res.last_out   <= 1'b1;
            res_valid      <= 1'b1;
            state          <= W_IDLE;
          end
        end
        default: state <= W_IDLE;
      endcase
    end
  end

  // a write_ok result only follows the header sweep
  a_ok_after_commit: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == ST_WRITE_OK) |-> $past(state == W_COMMIT))
    else $error("write_ok without header sweep");

  // tail moves only at the end of a commit
  a_tail_move: assert property (@(posedge clk) disable iff (rst)
    !$stable(tail) |-> $past(state == W_COMMIT))
    else $error("tail moved outside commit");

  // the sweep writes memory every cycle
  a_commit_writes: assert property (@(posedge clk) disable iff (rst)
    (state == W_COMMIT) |-> we)
    else $error("header sweep idle cycle");

  // a refused write never touches the ring
  a_refused_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == W_IDLE && wopen && wrefused && !req.first) |-> !we)
    else $error("refused write stored a byte");

endmodule

FILE: rtl/lpmr_rd.sv
module lpmr_rd #(
  parameter int RING_BYTES    = 1024,
  parameter int HEADER_BYTES  = 8,
  parameter int MAX_MSG_BYTES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [7:0]                    capacity,
  input  logic [$clog2(RING_BYTES)-1:0] tail,
  output logic [$clog2(RING_BYTES)-1:0] head,
  output logic                          busy,
  output logic                          re,
  output logic [$clog2(RING_BYTES)-1:0] raddr,
  input  logic [7:0]                    rdata,
  output lpmr_pkg::result_t             res,
  output logic                          res_valid
);
  import lpmr_pkg::*;

  localparam int AW  = $clog2(RING_BYTES);
  localparam int HCW = $clog2(HEADER_BYTES + 1);
  localparam logic [LEN_W-1:0] MAXL = LEN_W'(MAX_MSG_BYTES);

  typedef enum logic [4:0] {
    R_IDLE   = 5'b00001,
    R_HDR    = 5'b00010,
    R_HWAIT  = 5'b00100,
    R_STREAM = 5'b01000,
    R_DRAIN  = 5'b10000
  } rstate_t;

  rstate_t           state;
  logic [AW-1:0]     rptr;
  logic [HCW-1:0]    hcnt;
  logic [LEN_W-1:0]  scnt;
  logic [LEN_W-1:0]  len;
  logic [7:0]        cap;
  logic [7:0]        len_lo;
  logic              upper_nz;
  logic              hdr_first;
  logic              rvld;
  logic              rlast;

  logic [7:0]        lo_full;
  logic              up_full;
  logic [LEN_W-1:0]  len_c;
  logic              stream_end;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == AW'(RING_BYTES - 1)) r = '0;
    else                          r = p + AW'(1);
    return r;
  endfunction

  // header value with the final byte folded in, clamped to the largest message
  always_comb begin
    lo_full = hdr_first ? rdata : len_lo;
    up_full = upper_nz | (!hdr_first && (rdata != 8'h00));
    len_c   = (up_full || (lo_full > {1'b0, MAXL})) ? MAXL : lo_full[LEN_W-1:0];
  end

  assign stream_end = (scnt == len - LEN_W'(1));
  assign re         = (state == R_HDR) || (state == R_STREAM);
  assign raddr      = rptr;
  assign busy       = (state != R_IDLE);

  // read sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= R_IDLE;
      head      <= '0;
      rvld      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      rvld      <= re;
      rlast     <= (state == R_STREAM) && stream_end;
      unique case (state)
        R_IDLE: begin
          if (go) begin
            if (head == tail) begin
              res.status     <= ST_READ_EMPTY;
              res.out_len    <= '0;
              res.out_byte   <= '0;
              res.byte_valid <= 1'b0;
              res.last_out   <= 1'b1;
              res_valid      <= 1'b1;
            end else begin
              state     <= R_HDR;
              rptr      <= head;
              hcnt      <= '0;
              cap       <= capacity;
              hdr_first <= 1'b1;
              upper_nz  <= 1'b0;
            end
          end
        end
        R_HDR: begin
          rptr <= ptr_inc(rptr);
          hcnt <= hcnt + HCW'(1);
          if (rvld) begin
            if (hdr_first) begin
              len_lo    <= rdata;
              hdr_first <= 1'b0;
            end else begin
              upper_nz <= upper_nz | (rdata != 8'h00);
            end
          end
          if (hcnt == HCW'(HEADER_BYTES - 1)) begin
            state <= R_HWAIT;
          end
        end
        R_HWAIT: begin
          if (cap < {1'b0, len_c}) begin
            res.status     <= ST_READ_TOO_SMALL;
            res.out_len    <= len_c;
            res.out_byte   <= '0;
            res.byte_valid <= 1'b0;
            res.last_out   <= 1'b1;
            res_valid      <= 1'b1;
            state          <= R_IDLE;
          end else if (len_c == '0) begin
            res.status     <= ST_READ_OK;
            res.out_len    <= '0;
            res.out_byte   <= '0;
            res.byte_valid <= 1'b0;
            res.last_out   <= 1'b1;
            res_valid      <= 1'b1;
            head           <= rptr;
            state          <= R_IDLE;
          end else begin
            len   <= len_c;
            scnt  <= '0;
            state <= R_STREAM;
          end
        end
        R_STREAM: begin
          rptr <= ptr_inc(rptr);
          scnt <= scnt + LEN_W'(1);
          if (stream_end) begin
            head  <= ptr_inc(rptr);
            state <= R_DRAIN;
          end
        end
        R_DRAIN: begin
          state <= R_IDLE;
        end
        default: state <= R_IDLE;
      endcase
      // message bytes come back in the cycle after their fetch
      if (((state == R_STREAM) || (state == R_DRAIN)) && rvld) begin
        res.status     <= ST_READ_OK;
        res.out_len    <= len;
        res.out_byte   <= rdata;
        res.byte_valid <= 1'b1;
        res.last_out   <= rlast;
        res_valid      <= 1'b1;
      end
    end
  end

  // only read_ok words carry a byte
  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.byte_valid) |-> (res.status == ST_READ_OK))
    else $error("byte on a non-ok result");

  // head moves only on a successful read
  a_head_move: assert property (@(posedge clk) disable iff (rst)
    !$stable(head) |-> ($past(state == R_HWAIT) || $past(state == R_STREAM)))
    else $error("head moved outside a read");

  // the drain cycle always returns the final byte
  a_drain_last: assert property (@(posedge clk) disable iff (rst)
    (state == R_DRAIN) |-> (rvld && rlast))
    else $error("drain without final byte");

endmodule

FILE: rtl/length_prefixed_message_ring.sv
// Write word: the last word of an accepted message starts a header sweep that writes
//   HEADER_BYTES bytes into the ring, and its result follows it.
// Read word: empty result in the cycle after acceptance; otherwise a header fetch, then,
//   unless capacity is too small, one message byte per cycle from the ring read port.
// Busy during a header sweep or a non-empty read; the receiver cannot stall results.
// Reset clears pointers and write state; ring contents are not cleared.
module length_prefixed_message_ring #(
  parameter int RING_BYTES    = 1024,
  parameter int HEADER_BYTES  = 8,
  parameter int MAX_MSG_BYTES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  lpmr_pkg::req_t    req,
  output logic              busy,
  output logic              result_valid,
  output lpmr_pkg::result_t result
);
  import lpmr_pkg::*;

  localparam int AW = $clog2(RING_BYTES);

  logic          accept;
  logic          wr_go;
  logic          rd_go;
  logic          wr_busy;
  logic          rd_busy;
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  result_t       wr_res;
  result_t       rd_res;
  logic          wr_valid;
  logic          rd_valid;

  // route each accepted word to its side
  assign accept = start && !busy;
  assign wr_go  = accept && (req.req_type == REQ_WRITE);
  assign rd_go  = accept && (req.req_type == REQ_READ);
  assign busy   = wr_busy | rd_busy;

  lpmr_ram #(
    .WIDTH (8),
    .DEPTH (RING_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  lpmr_wr #(
    .RING_BYTES    (RING_BYTES),
    .HEADER_BYTES  (HEADER_BYTES),
    .MAX_MSG_BYTES (MAX_MSG_BYTES)
  ) u_wr (
    .clk       (clk),
    .rst       (rst),
    .go        (wr_go),
    .req       (req),
    .head      (head),
    .tail      (tail),
    .busy      (wr_busy),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .res       (wr_res),
    .res_valid (wr_valid)
  );

  lpmr_rd #(
    .RING_BYTES    (RING_BYTES),
    .HEADER_BYTES  (HEADER_BYTES),
    .MAX_MSG_BYTES (MAX_MSG_BYTES)
  ) u_rd (
    .clk       (clk),
    .rst       (rst),
    .go        (rd_go),
    .capacity  (req.read_capacity),
    .tail      (tail),
    .head      (head),
    .busy      (rd_busy),
    .re        (re),
    .raddr     (raddr),
    .rdata     (rdata),
    .res       (rd_res),
    .res_valid (rd_valid)
  );

  // result select; the two sides never report in the same cycle
  assign result_valid = wr_valid | rd_valid;
  assign result       = rd_valid ? rd_res : wr_res;

  a_one_source: assert property (@(posedge clk) disable iff (rst)
    !(wr_valid && rd_valid))
    else $error("both sides reported at once");

  a_single_side_busy: assert property (@(posedge clk) disable iff (rst)
    !(wr_busy && rd_busy))
    else $error("read and write sequencers active together");

  a_no_port_clash: assert property (@(posedge clk) disable iff (rst)
    (re && we) |-> (raddr != waddr))
    else $error("ring read and write hit the same byte");

endmodule

FILE: test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpmr_pkg::*;

  localparam int RING_BYTES    = 1024;
  localparam int HEADER_BYTES  = 8;
  localparam int MAX_MSG_BYTES = 64;
  localparam int RA_W          = $clog2(RING_BYTES);
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = HEADER_BYTES + MAX_MSG_BYTES + 16;

  typedef struct {
    req_t    w;
    bit      typed;
    status_t st;
    int      len;
  } stim_row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  req_t    req = '0;
  logic    busy;
  logic    result_valid;
  result_t result;

  // predictor copy of the ring
  logic [7:0] ring_mem [RING_BYTES];
  int         head_q;
  int         tail_q;
  int         wptr_q;
  bit         wr_open;
  bit         wr_refused;
  int         rcvd_cnt;
  int         decl_len;

  result_t    step_results[$];
  result_t    due_results[$];
  stim_row_t  stim_rows[$];
  int         mismatches = 0;
  int         items_sent = 0;
  int         space_refusals = 0;
  int         idle_pct = 0;

  length_prefixed_message_ring #(
    .RING_BYTES    (RING_BYTES),
    .HEADER_BYTES  (HEADER_BYTES),
    .MAX_MSG_BYTES (MAX_MSG_BYTES)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .req          (req),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic result_t mk_res(status_t st, int len, int b, bit v, bit l);
    result_t r;
    r.status     = st;
    r.out_len    = LEN_W'(len);
    r.out_byte   = BYTE_W'(b);
    r.byte_valid = v;
    r.last_out   = l;
    return r;
  endfunction

  function automatic req_t wr_word(bit f, bit l, int len, int b);
    req_t w;
    w.req_type      = REQ_WRITE;
    w.first         = f;
    w.last          = l;
    w.msg_len       = LEN_W'(len);
    w.data_byte     = BYTE_W'(b);
    w.read_capacity = BYTE_W'($urandom_range(0, 255));
    return w;
  endfunction

  function automatic req_t rd_word(int cap);
    req_t w;
    w.req_type      = REQ_READ;
    w.first         = 1'($urandom_range(0, 1));
    w.last          = 1'($urandom_range(0, 1));
    w.msg_len       = LEN_W'($urandom_range(0, 127));
    w.data_byte     = BYTE_W'($urandom_range(0, 255));
    w.read_capacity = BYTE_W'(cap);
    return w;
  endfunction

  function automatic int ring_free();
    if (head_q <= tail_q) return RING_BYTES - (tail_q - head_q);
    return head_q - tail_q;
  endfunction

  // expected results of one accepted word, left in step_results
  function automatic void ring_step(req_t w);
    logic [63:0] hdr;
    int          p;
    int          k;
    int          rlen;
    step_results.delete();
    if (w.req_type == REQ_READ) begin
      items_sent++;
      if (head_q == tail_q) begin
        step_results.push_back(mk_res(ST_READ_EMPTY, 0, 0, 1'b0, 1'b1));
        return;
      end
      // little-endian length header
      hdr = '0;
      p = head_q;
      for (k = 0; k < HEADER_BYTES; k++) begin
        hdr = hdr | (64'(ring_mem[RA_W'(p)]) << (8 * k));
        p = (p + 1) % RING_BYTES;
      end
      if (hdr > MAX_MSG_BYTES) hdr = 64'(MAX_MSG_BYTES);
      rlen = int'(hdr);
      if (int'(w.read_capacity) < rlen) begin
        step_results.push_back(mk_res(ST_READ_TOO_SMALL, rlen, 0, 1'b0, 1'b1));
        return;
      end
      if (rlen == 0) begin
        step_results.push_back(mk_res(ST_READ_OK, 0, 0, 1'b0, 1'b1));
        head_q = p;
        return;
      end
      for (k = 0; k < rlen; k++) begin
        step_results.push_back(mk_res(ST_READ_OK, rlen, int'(ring_mem[RA_W'(p)]), 1'b1,
                                      k + 1 == rlen));
        p = (p + 1) % RING_BYTES;
      end
      head_q = p;
      return;
    end

    // write word: a first word opens (or reopens) a message
    if (w.first) begin
      wr_open    = 1'b1;
      decl_len   = int'(w.msg_len);
      rcvd_cnt   = 0;
      wptr_q     = (tail_q + HEADER_BYTES) % RING_BYTES;
      wr_refused = (decl_len > MAX_MSG_BYTES) || (HEADER_BYTES + decl_len >= ring_free());
      if (wr_refused && decl_len <= MAX_MSG_BYTES) space_refusals++;
    end
    if (!wr_open) return;
    items_sent++;

    if (!wr_refused && rcvd_cnt < decl_len) begin
      ring_mem[RA_W'(wptr_q)] = w.data_byte;
      wptr_q = (wptr_q + 1) % RING_BYTES;
      rcvd_cnt++;
    end
    if (!w.last) return;

    if (wr_refused) begin
      step_results.push_back(mk_res(ST_WRITE_FULL, decl_len, 0, 1'b0, 1'b1));
    end else begin
      // header carries the count actually received
      p = tail_q;
      for (k = 0; k < HEADER_BYTES; k++) begin
        ring_mem[RA_W'(p)] = 8'(longint'(rcvd_cnt) >> (8 * k));
        p = (p + 1) % RING_BYTES;
      end
      tail_q = (tail_q + HEADER_BYTES + rcvd_cnt) % RING_BYTES;
      step_results.push_back(mk_res(ST_WRITE_OK, rcvd_cnt, 0, 1'b0, 1'b1));
    end
    wr_open    = 1'b0;
    wr_refused = 1'b0;
  endfunction

  // drive one word, wait for the handshake, then queue its expected results
  task automatic issue(req_t w, bit typed, result_t typed_res);
    @(negedge clk);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    req   <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    ring_step(w);
    if (typed) begin
      due_results.push_back(typed_res);
    end else begin
      foreach (step_results[i]) due_results.push_back(step_results[i]);
    end
  endtask

  task automatic add_row(req_t w, bit typed, status_t st, int len);
    stim_row_t r;
    r.w     = w;
    r.typed = typed;
    r.st    = st;
    r.len   = len;
    stim_rows.push_back(r);
  endtask

  function automatic int pick_cap();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 255);
      1:       return $urandom_range(0, 8);
      2:       return $urandom_range(0, 70);
      default: return 255;
    endcase
  endfunction

  task automatic send_read();
    issue(rd_word(pick_cap()), 1'b0, '0);
  endtask

  // one message: well formed, or with extra bytes, cut short, abandoned,
  // or with a read slipped in between its words
  task automatic send_message();
    int len;
    int kind;
    int n;
    int mid;
    bit abandon;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: len = $urandom_range(0, 6);
      5, 6, 7:       len = $urandom_range(7, 63);
      8:             len = MAX_MSG_BYTES;
      default:       len = $urandom_range(MAX_MSG_BYTES + 1, 127);
    endcase
    kind    = $urandom_range(0, 9);
    n       = (len > MAX_MSG_BYTES) ? $urandom_range(1, 4) : ((len == 0) ? 1 : len);
    abandon = (kind == 8);
    mid     = -1;
    if (kind == 6) n = n + $urandom_range(1, 3);
    if (kind == 7 && n > 1) n = $urandom_range(1, n - 1);
    if (abandon) n = $urandom_range(1, n);
    if (kind == 9 && n > 1) mid = $urandom_range(1, n - 1);
    for (int k = 0; k < n; k++) begin
      if (k == mid) send_read();
      issue(wr_word(k == 0, (k == n - 1) && !abandon,
                    (k == 0) ? len : $urandom_range(0, 127), $urandom_range(0, 255)),
            1'b0, '0);
    end
  endtask

  // one random phase; fill runs on until 3 space refusals or 400 items
  task automatic run_phase(int idle, int rd_pct, int quota, bit fill);
    int base;
    int pick;
    base     = items_sent;
    idle_pct = idle;
    while (items_sent - base < quota ||
           (fill && space_refusals < 3 && items_sent - base < 400)) begin
      pick = $urandom_range(0, 99);
      if (pick < rd_pct) begin
        send_read();
      end else if (pick < rd_pct + (fill ? 92 : 15)) begin
        // single word message
        issue(wr_word(1'b1, 1'b1,
                      (fill && $urandom_range(0, 9) < 8) ? 0 : $urandom_range(0, 70),
                      $urandom_range(0, 255)), 1'b0, '0);
      end else if (pick < rd_pct + (fill ? 95 : 20)) begin
        // stray word without a first mark
        issue(wr_word(1'b0, 1'($urandom_range(0, 1)), $urandom_range(0, 127),
                      $urandom_range(0, 255)), 1'b0, '0);
      end else begin
        send_message();
      end
    end
  endtask

  // sender holds off until every expected word has come back
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    result_t exp_res;
    if (!rst && result_valid === 1'b1) begin
      if (due_results.size() == 0) begin
        $error("result word with nothing expected: %h", result);
        mismatches++;
      end else begin
        exp_res = due_results.pop_front();
        if (result.status !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, result.status);
          mismatches++;
        end
        if (result.out_len !== exp_res.out_len) begin
          $error("out_len: expected %0d, actual %0d", exp_res.out_len, result.out_len);
          mismatches++;
        end
        if (result.out_byte !== exp_res.out_byte) begin
          $error("out_byte: expected %h, actual %h", exp_res.out_byte, result.out_byte);
          mismatches++;
        end
        if (result.byte_valid !== exp_res.byte_valid) begin
          $error("byte_valid: expected %b, actual %b", exp_res.byte_valid, result.byte_valid);
          mismatches++;
        end
        if (result.last_out !== exp_res.last_out) begin
          $error("last_out: expected %b, actual %b", exp_res.last_out, result.last_out);
          mismatches++;
        end
      end
    end
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin
    foreach (ring_mem[i]) ring_mem[i] = 8'h00;
    head_q     = 0;
    tail_q     = 0;
    wptr_q     = 0;
    wr_open    = 1'b0;
    wr_refused = 1'b0;
    rcvd_cnt   = 0;
    decl_len   = 0;

    // directed table: empty ring, zero length, refusals, extra and missing
    // bytes, too-small reads, a read during an open write, abandoned write
    add_row(rd_word(0), 1'b1, ST_READ_EMPTY, 0);
    add_row(wr_word(1'b0, 1'b1, 5, 8'h11), 1'b0, ST_WRITE_OK, 0);
    add_row(wr_word(1'b1, 1'b1, 0, 8'hFF), 1'b1, ST_WRITE_OK, 0);
    add_row(rd_word(0), 1'b1, ST_READ_OK, 0);
    add_row(wr_word(1'b1, 1'b1, 127, 8'h00), 1'b1, ST_WRITE_FULL, 127);
    add_row(wr_word(1'b1, 1'b0, 65, 8'hAA), 1'b0, ST_WRITE_OK, 0);
    add_row(wr_word(1'b0, 1'b1, 0, 8'h55), 1'b1, ST_WRITE_FULL, 65);
    add_row(wr_word(1'b1, 1'b0, 3, 8'h00), 1'b0, ST_WRITE_OK, 0);
    add_row(wr_word(1'b0, 1'b0, 127, 8'hFF), 1'b0, ST_WRITE_OK, 0);
    add_row(wr_word(1'b0, 1'b0, 0, 8'hA5), 1'b0, ST_WRITE_OK, 0);
    add_row(wr_word(1'b0, 1'b1, 64, 8'h5A), 1'b1, ST_WRITE_OK, 3);
    add_row(rd_word(2), 1'b1, ST_READ_TOO_SMALL, 3);
    add_row(rd_word(3), 1'b0, ST_READ_OK, 0);
    add_row(wr_word(1'b1, 1'b0, 64, 8'h01), 1'b0, ST_WRITE_OK, 0);
    add_row(wr_word(1'b0, 1'b1, 0, 8'h80), 1'b1, ST_WRITE_OK, 2);
    add_row(wr_word(1'b1, 1'b0, 2, 8'h33), 1'b0, ST_WRITE_OK, 0);
    add_row(rd_word(255), 1'b0, ST_READ_OK, 0);
    add_row(wr_word(1'b1, 1'b1, 1, 8'h7E), 1'b1, ST_WRITE_OK, 1);
    add_row(rd_word(255), 1'b0, ST_READ_OK, 0);
    add_row(rd_word(255), 1'b1, ST_READ_EMPTY, 0);
    add_row(wr_word(1'b1, 1'b1, 64, 8'hFF), 1'b1, ST_WRITE_OK, 1);
    add_row(rd_word(0), 1'b1, ST_READ_TOO_SMALL, 1);
    add_row(rd_word(1), 1'b0, ST_READ_OK, 0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i])
      issue(stim_rows[i].w, stim_rows[i].typed,
            mk_res(stim_rows[i].st, stim_rows[i].len, 0, 1'b0, 1'b1));
    settle();

    // fill the ring, then mixed traffic under several gap rates, then drain
    run_phase(0, 5, 110, 1'b1);
    settle();
    run_phase(61, 35, 75, 1'b0);
    settle();
    run_phase(0, 35, 75, 1'b0);
    run_phase(10, 35, 75, 1'b0);
    run_phase(0, 70, 40, 1'b0);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/lpmr_pkg.sv
rtl/lpmr_ram.sv
rtl/lpmr_wr.sv
rtl/lpmr_rd.sv
rtl/length_prefixed_message_ring.sv
test/tb.sv
